FILE: hdl/pcg_pkg.sv
package pcg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // shared widths
  localparam int ATAN_N     = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_N);
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int XY_W       = 33;
  localparam int DIV_W      = 38;
  localparam int DVS_W      = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // fixed-point constants
  localparam logic [31:0]       THETA_RESET      = 32'd838861;
  localparam logic [31:0]       THETA_WRAP       = 32'd3373259426;
  localparam logic [DVS_W-1:0]  TWO_PI_Q24       = 27'd105414357;
  localparam logic [29:0]       TURN_PER_RAD_Q24 = 30'd683565276;
  localparam logic [22:0]       INV_PI_Q24       = 23'd5340354;
  localparam logic [22:0]       PI_2000_Q32      = 23'd6746519;
  localparam logic [13:0]       DELTA_BIAS       = 14'd42;
  localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic [18:0]       SPEED_MIN        = 19'd1678;
  localparam logic [18:0]       SPEED_MAX        = 19'd335544;
  localparam logic [18:0]       SPEED_SPAN       = 19'd333866;
  localparam logic [18:0]       SPEED_DIAL_RST   = 19'd167772;
  localparam logic [11:0]       CV_RND           = 12'd2047;
  localparam logic [4:0]        COEFF_MAX        = 5'd20;

  // reciprocals: ceil(2^43 / 4095), exact for the CV range; floor(2^58 / (2*pi in Q24))
  localparam logic [31:0]       CV_RECIP         = 32'd2148008065;
  localparam logic [31:0]       MOD_RECIP        = 32'd2734261104;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_DIAL = 2'd0,
    REG_COEFF_A    = 2'd1,
    REG_COEFF_B    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EQ_SIN_COS    = 2'd0,
    EQ_SIN_INNER  = 2'd1,
    EQ_COS_INNER  = 2'd2,
    EQ_RATIO      = 2'd3
  } eq_e;

  typedef enum logic [1:0] {
    MULT_HALF   = 2'd0,
    MULT_UNITY  = 2'd1,
    MULT_DOUBLE = 2'd2
  } mult_e;

  typedef enum logic [1:0] {
    JOB_OUT,
    JOB_FIRST,
    JOB_SECOND,
    JOB_INNER
  } job_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_MOD_REM,
    ST_TURN_MUL,
    ST_CORD_START,
    ST_CORD_WAIT,
    ST_OUT_X,
    ST_OUT_Y,
    ST_OUT_YSAVE,
    ST_SPD_MUL,
    ST_SPD_DIV,
    ST_SPD_WAIT,
    ST_DELTA_MUL,
    ST_PHASE,
    ST_ANG_MUL,
    ST_ANG_SAVE,
    ST_QUO_START,
    ST_QUO_WAIT,
    ST_INNER_K,
    ST_INNER_MUL,
    ST_PROD_MUL,
    ST_PROD_SAVE,
    ST_FINISH
  } st_e;

  typedef struct packed {
    logic [11:0] speed_cv;
    logic        cv_connected;
    logic        mult_button;
    logic        prev_button;
    logic        next_button;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] radius_out;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [1:0]         equation_index;
    logic [1:0]         multiplier_index;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] turn;
  } cord_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [XY_W-1:0] sin;
    logic signed [XY_W-1:0] cos;
  } cord_rsp_t;

endpackage

FILE: hdl/pcg_if.sv
interface pcg_in_if;
  logic               valid;
  logic               ready;
  pcg_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcg_out_if;
  logic               valid;
  logic               ready;
  pcg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pcg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcg_pkg::CFG_IDX_W-1:0]    index;
  logic [pcg_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/polar_curve_cv_generator_top.sv
// Channel   Dir  Payload                                            Handshake
// in_ch     in   speed_cv, cv_connected, mult/prev/next_button      valid/ready
// out_ch    out  radius_out, x_out, y_out, equation/multiplier idx  valid/ready
// cfg_ch    in   index (0 dial, 1 coeff A, 2 coeff B), data         valid/ready, always ready
//
// One item is worked at a time; in_ch.ready is high only while the sequencer idles.
// An item is worked as a series of steps: reductions modulo 2*pi on the shared
// multiplier, CORDIC runs, the ratio division and a CV speed; the equation
// and the speed source pick how many of each.
// rst_ni clears the sequencer, cursor, selections and config registers at once; no clearing pass.
// A result waits in the output register; the next item may be taken while it stalls,
// and its own result is held back in the final state until the register frees.
module polar_curve_cv_generator_top #(
  parameter int CORDIC_STEPS = pcg_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcg_in_if.sink     in_ch,
  pcg_out_if.source  out_ch,
  pcg_cfg_if.sink    cfg_ch
);

  localparam int MW = pcg_pkg::MUL_W;
  localparam int PW = pcg_pkg::PROD_W;
  localparam int XW = pcg_pkg::XY_W;
  localparam int DW = pcg_pkg::DIV_W;
  localparam int VW = pcg_pkg::DVS_W;

  pcg_pkg::st_e  state_q, state_d;
  pcg_pkg::job_e job_q;
  pcg_pkg::eq_e  eq_q;
  logic [1:0]    mult_q;
  logic          last_mult_q, last_next_q, last_prev_q;
  logic [31:0]   phase_q;
  logic signed [15:0] radius_q;

  logic [18:0]   speed_dial_q;
  logic [4:0]    coeff_a_q, coeff_b_q;

  // per-item working registers
  logic [11:0]          cv_q;
  logic                 conn_q;
  logic [DW-1:0]        ang_q;
  logic [VW-1:0]        mod_rem_q;
  logic [18:0]          speed_q;
  logic signed [XW-1:0] s1_q, c2_q;
  logic signed [XW:0]   r30_q;
  logic signed [15:0]   xo_q, yo_q;

  pcg_pkg::out_item_t   out_q;
  logic                 out_valid_q;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  pcg_pkg::div_req_t    div_req;
  pcg_pkg::div_rsp_t    div_rsp;
  pcg_pkg::cord_req_t   cord_req;
  pcg_pkg::cord_rsp_t   cord_rsp;

  logic in_acc, cfg_acc, out_free;

  pcg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pcg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .rsp_o  (cord_rsp)
  );

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Q60 product back to Q30, round half up
  function automatic logic signed [35:0] rnd30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< 29)) >>> 30;
    return t[35:0];
  endfunction

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign cfg_acc  = cfg_ch.valid & cfg_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;

  assign in_ch.ready  = (state_q == pcg_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  // coefficients saturate at 10.0
  logic [4:0] a_c, b_c;
  assign a_c = (coeff_a_q > pcg_pkg::COEFF_MAX) ? pcg_pkg::COEFF_MAX : coeff_a_q;
  assign b_c = (coeff_b_q > pcg_pkg::COEFF_MAX) ? pcg_pkg::COEFF_MAX : coeff_b_q;

  logic inner_eq;
  assign inner_eq = (eq_q == pcg_pkg::EQ_SIN_INNER) || (eq_q == pcg_pkg::EQ_COS_INNER);

  // button edges on the incoming item
  logic [1:0]   mult_nxt;
  logic [1:0]   eq_up, eq_nxt;
  always_comb begin
    mult_nxt = mult_q;
    if (in_ch.data.mult_button != last_mult_q) begin
      case (mult_q)
        pcg_pkg::MULT_HALF:   mult_nxt = pcg_pkg::MULT_UNITY;
        pcg_pkg::MULT_UNITY:  mult_nxt = pcg_pkg::MULT_DOUBLE;
        pcg_pkg::MULT_DOUBLE: mult_nxt = pcg_pkg::MULT_HALF;
        default:              mult_nxt = pcg_pkg::MULT_UNITY;
      endcase
    end
    eq_up  = ((~in_ch.data.next_button) != last_next_q) ? eq_q + 2'd1 : eq_q;
    eq_nxt = ((~in_ch.data.prev_button) != last_prev_q) ? eq_up - 2'd1 : eq_up;
  end

  // dial speed clamp
  logic [18:0] dial_c;
  assign dial_c = (speed_dial_q < pcg_pkg::SPEED_MIN) ? pcg_pkg::SPEED_MIN :
                  (speed_dial_q > pcg_pkg::SPEED_MAX) ? pcg_pkg::SPEED_MAX : speed_dial_q;

  // phase step: (speed*K*q + 2^33) >> 34 + 42, q = m^2 in quarters
  logic [47:0] dsum;
  logic [13:0] delta;
  logic [32:0] phase_sum;
  logic [31:0] phase_nxt;
  always_comb begin
    case (mult_q)
      pcg_pkg::MULT_HALF:   dsum = {6'd0, prod[41:0]};
      pcg_pkg::MULT_DOUBLE: dsum = {2'd0, prod[41:0], 4'd0};
      default:              dsum = {4'd0, prod[41:0], 2'd0};
    endcase
    dsum      = dsum + (48'd1 << 33);
    delta     = dsum[47:34] + pcg_pkg::DELTA_BIAS;
    phase_sum = {1'b0, phase_q} + {19'd0, delta};
    phase_nxt = (phase_sum > {1'b0, pcg_pkg::THETA_WRAP}) ?
                32'(phase_sum - {1'b0, pcg_pkg::THETA_WRAP}) : phase_sum[31:0];
  end

  // angle mod 2*pi: quotient estimate is exact or one short, one subtract fixes it
  logic [DW-1:0] mod_diff, mod_fix;
  assign mod_diff = ang_q - prod[DW-1:0];
  assign mod_fix  = (mod_diff >= DW'(pcg_pkg::TWO_PI_Q24)) ?
                    mod_diff - DW'(pcg_pkg::TWO_PI_Q24) : mod_diff;

  // radians to turn, rounded; inner angle takes the sign of cos
  logic [57:0] turn_rnd;
  logic [31:0] turn_abs;
  assign turn_rnd = prod[57:0] + (58'd1 << 23);
  assign turn_abs = turn_rnd[55:24];

  logic [XW-1:0] c2_abs;
  assign c2_abs = c2_q[XW-1] ? XW'(-c2_q) : c2_q;

  logic signed [PW-1:0] prod_rnd;
  assign prod_rnd = (prod + (PW'(1) <<< 29)) >>> 30;

  logic signed [XW:0] r30_rnd;
  assign r30_rnd = (r30_q + (XW+1)'(1 <<< 14)) >>> 15;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcg_pkg::ST_IDLE:       if (in_acc) state_d = pcg_pkg::ST_MOD_START;
      pcg_pkg::ST_MOD_START:  state_d = pcg_pkg::ST_MOD_WAIT;
      pcg_pkg::ST_MOD_WAIT:   state_d = pcg_pkg::ST_MOD_REM;
      pcg_pkg::ST_MOD_REM:    state_d = pcg_pkg::ST_TURN_MUL;
      pcg_pkg::ST_TURN_MUL:   state_d = pcg_pkg::ST_CORD_START;
      pcg_pkg::ST_CORD_START: state_d = pcg_pkg::ST_CORD_WAIT;
      pcg_pkg::ST_CORD_WAIT: begin
        if (cord_rsp.done) begin
          unique case (job_q)
            pcg_pkg::JOB_OUT:    state_d = pcg_pkg::ST_OUT_X;
            pcg_pkg::JOB_SECOND: state_d = pcg_pkg::ST_PROD_MUL;
            pcg_pkg::JOB_INNER:  state_d = pcg_pkg::ST_FINISH;
            default: begin
              if (eq_q == pcg_pkg::EQ_SIN_COS) begin
                state_d = pcg_pkg::ST_ANG_MUL;
              end else if (inner_eq) begin
                state_d = pcg_pkg::ST_INNER_K;
              end else begin
                state_d = pcg_pkg::ST_FINISH;
              end
            end
          endcase
        end
      end
      pcg_pkg::ST_OUT_X:      state_d = pcg_pkg::ST_OUT_Y;
      pcg_pkg::ST_OUT_Y:      state_d = pcg_pkg::ST_OUT_YSAVE;
      pcg_pkg::ST_OUT_YSAVE:  state_d = conn_q ? pcg_pkg::ST_SPD_MUL : pcg_pkg::ST_DELTA_MUL;
      pcg_pkg::ST_SPD_MUL:    state_d = pcg_pkg::ST_SPD_DIV;
      pcg_pkg::ST_SPD_DIV:    state_d = pcg_pkg::ST_SPD_WAIT;
      pcg_pkg::ST_SPD_WAIT:   state_d = pcg_pkg::ST_DELTA_MUL;
      pcg_pkg::ST_DELTA_MUL:  state_d = pcg_pkg::ST_PHASE;
      pcg_pkg::ST_PHASE: begin
        if (eq_q == pcg_pkg::EQ_RATIO && b_c == 5'd0) begin
          state_d = pcg_pkg::ST_FINISH;
        end else begin
          state_d = pcg_pkg::ST_ANG_MUL;
        end
      end
      pcg_pkg::ST_ANG_MUL:    state_d = pcg_pkg::ST_ANG_SAVE;
      pcg_pkg::ST_ANG_SAVE: begin
        if (eq_q == pcg_pkg::EQ_RATIO) begin
          state_d = pcg_pkg::ST_QUO_START;
        end else begin
          state_d = pcg_pkg::ST_MOD_START;
        end
      end
      pcg_pkg::ST_QUO_START:  state_d = pcg_pkg::ST_QUO_WAIT;
      pcg_pkg::ST_QUO_WAIT:   if (div_rsp.done) state_d = pcg_pkg::ST_MOD_START;
      pcg_pkg::ST_INNER_K:    state_d = pcg_pkg::ST_INNER_MUL;
      pcg_pkg::ST_INNER_MUL:  state_d = pcg_pkg::ST_CORD_START;
      pcg_pkg::ST_PROD_MUL:   state_d = pcg_pkg::ST_PROD_SAVE;
      pcg_pkg::ST_PROD_SAVE:  state_d = pcg_pkg::ST_FINISH;
      pcg_pkg::ST_FINISH:     if (out_free) state_d = pcg_pkg::ST_IDLE;
      default:                state_d = pcg_pkg::ST_IDLE;
    endcase
  end

  // unit requests per state
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = ang_q;
    div_req.divisor  = pcg_pkg::TWO_PI_Q24;
    cord_req.start   = 1'b0;
    cord_req.turn    = turn_abs;
    unique case (state_q)
      pcg_pkg::ST_MOD_START: begin
        // quotient estimate: (angle >> 6) * 2^58/C, taken >> 52
        mul_a = MW'(ang_q[DW-1:6]);
        mul_b = MW'(pcg_pkg::MOD_RECIP);
      end
      pcg_pkg::ST_MOD_WAIT: begin
        mul_a = MW'(prod[63:52]);
        mul_b = MW'(pcg_pkg::TWO_PI_Q24);
      end
      pcg_pkg::ST_TURN_MUL: begin
        mul_a = MW'(mod_rem_q);
        mul_b = MW'(pcg_pkg::TURN_PER_RAD_Q24);
      end
      pcg_pkg::ST_CORD_START: begin
        cord_req.start = 1'b1;
        if (job_q == pcg_pkg::JOB_INNER && c2_q[XW-1]) begin
          cord_req.turn = -turn_abs;
        end
      end
      pcg_pkg::ST_OUT_X: begin
        mul_a = MW'(radius_q);
        mul_b = cord_rsp.sin;
      end
      pcg_pkg::ST_OUT_Y: begin
        mul_a = MW'(radius_q);
        mul_b = cord_rsp.cos;
      end
      pcg_pkg::ST_SPD_MUL: begin
        mul_a = MW'(cv_q);
        mul_b = MW'(pcg_pkg::SPEED_SPAN);
      end
      pcg_pkg::ST_SPD_DIV: begin
        // divide by 4095 as a reciprocal product, quotient in bits 61:43
        mul_a = MW'(prod[31:0] + 32'(pcg_pkg::CV_RND));
        mul_b = MW'(pcg_pkg::CV_RECIP);
      end
      pcg_pkg::ST_DELTA_MUL: begin
        mul_a = MW'(speed_q);
        mul_b = MW'(pcg_pkg::PI_2000_Q32);
      end
      pcg_pkg::ST_ANG_MUL: begin
        mul_a = (job_q == pcg_pkg::JOB_SECOND || inner_eq) ? MW'(b_c) : MW'(a_c);
        mul_b = MW'(phase_q);
      end
      pcg_pkg::ST_QUO_START: begin
        div_req.start   = 1'b1;
        div_req.divisor = VW'(b_c);
      end
      pcg_pkg::ST_INNER_K: begin
        mul_a = MW'(a_c);
        mul_b = MW'(pcg_pkg::INV_PI_Q24);
      end
      pcg_pkg::ST_INNER_MUL: begin
        mul_a = signed'(c2_abs);
        mul_b = prod[MW-1:0];
      end
      pcg_pkg::ST_PROD_MUL: begin
        mul_a = s1_q;
        mul_b = c2_q;
      end
      default: ;
    endcase
  end

  // control and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pcg_pkg::ST_IDLE;
      job_q        <= pcg_pkg::JOB_OUT;
      eq_q         <= pcg_pkg::EQ_SIN_INNER;
      mult_q       <= pcg_pkg::MULT_UNITY;
      last_mult_q  <= 1'b0;
      last_next_q  <= 1'b0;
      last_prev_q  <= 1'b0;
      phase_q      <= pcg_pkg::THETA_RESET;
      radius_q     <= '0;
      speed_dial_q <= pcg_pkg::SPEED_DIAL_RST;
      coeff_a_q    <= 5'd1;
      coeff_b_q    <= 5'd1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          pcg_pkg::REG_SPEED_DIAL: speed_dial_q <= cfg_ch.data;
          pcg_pkg::REG_COEFF_A:    coeff_a_q    <= cfg_ch.data[4:0];
          pcg_pkg::REG_COEFF_B:    coeff_b_q    <= cfg_ch.data[4:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        job_q       <= pcg_pkg::JOB_OUT;
        mult_q      <= mult_nxt;
        eq_q        <= pcg_pkg::eq_e'(eq_nxt);
        last_mult_q <= in_ch.data.mult_button;
        last_next_q <= ~in_ch.data.next_button;
        last_prev_q <= ~in_ch.data.prev_button;
      end
      if (state_q == pcg_pkg::ST_PHASE) begin
        phase_q <= phase_nxt;
        job_q   <= pcg_pkg::JOB_FIRST;
      end
      if (state_q == pcg_pkg::ST_CORD_WAIT && cord_rsp.done &&
          job_q == pcg_pkg::JOB_FIRST && eq_q == pcg_pkg::EQ_SIN_COS) begin
        job_q <= pcg_pkg::JOB_SECOND;
      end
      if (state_q == pcg_pkg::ST_INNER_K) begin
        job_q <= pcg_pkg::JOB_INNER;
      end
      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == pcg_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        radius_q    <= sat16(36'(r30_rnd));
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cv_q    <= in_ch.data.speed_cv;
      conn_q  <= in_ch.data.cv_connected;
      speed_q <= dial_c;
      ang_q   <= {5'd0, phase_q, 1'b0};
    end
    unique case (state_q)
      pcg_pkg::ST_MOD_REM:   mod_rem_q <= mod_fix[VW-1:0];
      pcg_pkg::ST_OUT_Y:     xo_q <= sat16(rnd30(prod));
      pcg_pkg::ST_OUT_YSAVE: yo_q <= sat16(rnd30(prod));
      pcg_pkg::ST_SPD_WAIT:  speed_q <= pcg_pkg::SPEED_MIN + prod[61:43];
      pcg_pkg::ST_PHASE:     r30_q <= '0;
      pcg_pkg::ST_ANG_SAVE: begin
        if (eq_q == pcg_pkg::EQ_RATIO) begin
          ang_q <= {prod[DW-2:0], 1'b0};
        end else begin
          ang_q <= prod[DW-1:0];
        end
      end
      pcg_pkg::ST_QUO_WAIT:  if (div_rsp.done) ang_q <= div_rsp.quot;
      pcg_pkg::ST_CORD_WAIT: begin
        if (cord_rsp.done) begin
          if (job_q == pcg_pkg::JOB_FIRST) begin
            s1_q  <= cord_rsp.sin;
            c2_q  <= cord_rsp.cos;
            r30_q <= (XW+1)'(cord_rsp.sin);
          end else if (job_q == pcg_pkg::JOB_SECOND) begin
            c2_q <= cord_rsp.cos;
          end else if (job_q == pcg_pkg::JOB_INNER) begin
            r30_q <= (eq_q == pcg_pkg::EQ_SIN_INNER) ? (XW+1)'(cord_rsp.sin) :
                                                       (XW+1)'(cord_rsp.cos);
          end
        end
      end
      pcg_pkg::ST_PROD_SAVE: r30_q <= prod_rnd[XW:0];
      pcg_pkg::ST_FINISH: begin
        if (out_free) begin
          out_q.radius_out       <= radius_q;
          out_q.x_out            <= xo_q;
          out_q.y_out            <= yo_q;
          out_q.equation_index   <= eq_q;
          out_q.multiplier_index <= mult_q;
        end
      end
      default: ;
    endcase
  end

  // shared units are never restarted mid-run
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_cord_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_req.start |-> !cord_rsp.busy)
    else $error("cordic started while busy");

  // selection only moves on an input transfer
  a_eq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(eq_q) && $stable(mult_q))
    else $error("selection changed without input transfer");

  // a result is loaded only from the final state
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == pcg_pkg::ST_FINISH)
    else $error("output loaded outside finish");

endmodule

FILE: hdl/pcg_mul.sv
module pcg_mul (
  input  logic                                clk_i,
  input  logic signed [pcg_pkg::MUL_W-1:0]    a_i,
  input  logic signed [pcg_pkg::MUL_W-1:0]    b_i,
  output logic signed [pcg_pkg::PROD_W-1:0]   p_o
);

  logic signed [pcg_pkg::PROD_W-1:0] p_q;

  // product is registered: it lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: hdl/pcg_div.sv
module pcg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcg_pkg::div_req_t   req_i,
  output pcg_pkg::div_rsp_t   rsp_o
);

  localparam int DW    = pcg_pkg::DIV_W;
  localparam int VW    = pcg_pkg::DVS_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    num_q;
  logic [VW-1:0]    den_q, rem_q;
  logic [VW:0]      trial, diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[DW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DW-2:0], fits};
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/pcg_cordic.sv
module pcg_cordic #(
  parameter int STEPS = pcg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcg_pkg::cord_req_t  req_i,
  output pcg_pkg::cord_rsp_t  rsp_o
);

  localparam int IW = pcg_pkg::ATAN_IDX_W;
  localparam int XW = pcg_pkg::XY_W;

  logic                 busy_q, done_q, flip_q;
  logic [IW-1:0]        i_q;
  logic signed [XW-1:0] x_q, y_q, z_q;
  logic signed [XW-1:0] dx, dy, at, nx, ny, nz;
  logic                 last;
  logic                 flip;
  logic [31:0]          u;

  // fold the turn into the right half plane
  assign flip = req_i.turn[31] ^ req_i.turn[30];
  assign u    = {req_i.turn[31] ^ flip, req_i.turn[30:0]};

  assign dx   = y_q >>> i_q;
  assign dy   = x_q >>> i_q;
  assign at   = signed'({1'b0, pcg_pkg::ATAN_TURNS[i_q]});
  assign last = (i_q == IW'(STEPS - 1));

  always_comb begin
    if (!z_q[XW-1]) begin
      nx = x_q - dx;
      ny = y_q + dy;
      nz = z_q - at;
    end else begin
      nx = x_q + dx;
      ny = y_q - dy;
      nz = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      flip_q <= flip;
      x_q    <= pcg_pkg::INV_GAIN_Q30;
      y_q    <= '0;
      z_q    <= signed'({u[31], u});
    end else if (busy_q) begin
      z_q <= nz;
      if (last && flip_q) begin
        x_q <= -nx;
        y_q <= -ny;
      end else begin
        x_q <= nx;
        y_q <= ny;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sin  = y_q;
  assign rsp_o.cos  = x_q;

endmodule
